// File: design/lane_mds_linear_layer_1600_defines.svh
// Assertion macros for the 1600-bit linear layer.
`ifndef LANE_MDS_LINEAR_LAYER_1600_DEFINES_SVH
`define LANE_MDS_LINEAR_LAYER_1600_DEFINES_SVH

`ifndef SYNTHESIS
`define LMDS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lmds assertion failed");
`define LMDS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lmds assertion failed");
`else
`define LMDS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define LMDS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// File: design/lmds_pkg.sv
// Types, constants and helper functions of the 1600-bit linear layer.
package lmds_pkg;

  localparam int NLANES = 25;
  localparam int LANE_W = 64;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NLANES - 1);

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t lanes_t [NLANES];

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_TAU,
    OP_MIX,
    OP_RPM,
    OP_ITAU
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take_round;
  } cmd_t;

  localparam logic [4:0] MDS_COEF [5][5] = '{
    '{5'h11, 5'h13, 5'h02, 5'h01, 5'h05},
    '{5'h10, 5'h06, 5'h01, 5'h02, 5'h09},
    '{5'h13, 5'h11, 5'h05, 5'h09, 5'h02},
    '{5'h06, 5'h10, 5'h09, 5'h05, 5'h01},
    '{5'h01, 5'h09, 5'h10, 5'h11, 5'h06}
  };

  localparam logic [5:0] ROT_AMT [NLANES] = '{
    6'd0,  6'd5,  6'd14, 6'd10, 6'd28,
    6'd1,  6'd9,  6'd6,  6'd15, 6'd33,
    6'd3,  6'd23, 6'd25, 6'd29, 6'd39,
    6'd7,  6'd11, 6'd8,  6'd37, 6'd43,
    6'd19, 6'd24, 6'd21, 6'd34, 6'd27
  };

  // round mod 6 via reciprocal: q = (r * 171) >> 10 is exact for 8-bit r
  function automatic logic [2:0] mod6(input logic [7:0] r);
    logic [15:0] p;
    logic [5:0]  q;
    logic [7:0]  q6;
    logic [7:0]  rem;
    p   = 16'(r) * 16'd171;
    q   = p[15:10];
    q6  = 8'({q, 2'b00}) + 8'({q, 1'b0});
    rem = r - q6;
    return rem[2:0];
  endfunction

  // Mask of source slice bits feeding output slice bit k of c * s in GF(32),
  // modulus a^5 + a^2 + 1.
  function automatic logic [4:0] mul_mask(input logic [4:0] c, input int k);
    logic [4:0] p [5];
    logic [4:0] acc;
    logic [4:0] top;
    for (int m = 0; m < 5; m++) p[m] = 5'(1) << m;
    acc = '0;
    for (int b = 0; b < 5; b++) begin
      if (c[b]) acc ^= p[k];
      top  = p[4];
      p[4] = p[3];
      p[3] = p[2];
      p[2] = p[1] ^ top;
      p[1] = p[0];
      p[0] = top;
    end
    return acc;
  endfunction

  // Source lane of destination lane dest under tau_d.
  function automatic int tau_src(input int d, input int dest);
    int nx;
    int ny;
    nx = dest % 5;
    ny = dest / 5;
    return ny + 5 * ((nx + d * ny) % 5);
  endfunction

  // Source lane of destination lane dest under the inverse of tau_d.
  function automatic int itau_src(input int d, input int dest);
    int nx;
    int ny;
    nx = dest % 5;
    ny = dest / 5;
    return ((ny + 25 - d * nx) % 5) + 5 * nx;
  endfunction

  function automatic lane_t rotr(input lane_t v, input int n);
    logic [2*LANE_W-1:0] t;
    t = {v, v} >> n;
    return t[LANE_W-1:0];
  endfunction

endpackage

// File: design/lane_mds_linear_layer_1600.sv
// Top level of the 1600-bit linear layer: sequencer plus state datapath.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: lane_value, round_number
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_lane, tlast: out_last
//
// A state is loaded one lane a word, transformed by tau, column mix,
// rotate/pi/mu and inverse tau, then emitted. The single 25-lane state
// register carries load, transform and emit, so loads wait until the last
// state is emitted. rst is synchronous; after it the block waits for
// lane 0. Output stalls hold the emit shift; input words wait while busy.
`include "lane_mds_linear_layer_1600_defines.svh"

module lane_mds_linear_layer_1600 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] lane_value, [71:64] round_number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] out_lane
  output logic        m_axis_tlast    // out_last
);

  lmds_pkg::cmd_t cmd;

  lmds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_last  (m_axis_tlast),
    .cmd       (cmd)
  );

  lmds_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_lane  (s_axis_tdata[63:0]),
    .in_round (s_axis_tdata[71:64]),
    .out_lane (m_axis_tdata)
  );

  `LMDS_ASSERT_IMPLIES(a_no_overlap, clk, rst, s_axis_tready, !m_axis_tvalid)
  `LMDS_ASSERT_IMPLIES(a_last_valid, clk, rst, m_axis_tlast, m_axis_tvalid)
  `LMDS_ASSERT_NEXT(a_reload, clk, rst,
    m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid)
  `LMDS_ASSERT_IMPLIES(a_shift_only_hs, clk, rst, cmd.op == lmds_pkg::OP_SHIFT,
    (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))

endmodule

// File: design/lmds_ctrl.sv
// Sequencer: lane count, handshakes and step commands for the datapath.
module lmds_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output logic            out_last,
  output lmds_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_TAU,
    S_MIX,
    S_RPM,
    S_ITAU,
    S_EMIT
  } fsm_t;

  fsm_t                         state;
  logic [lmds_pkg::CNT_W-1:0]   cnt;
  logic                         in_take;
  logic                         out_take;

  assign in_take  = in_valid & in_ready;
  assign out_take = out_valid & out_ready;

  always_comb begin
    cmd.op         = lmds_pkg::OP_HOLD;
    cmd.take_round = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (in_take) begin
          cmd.op         = lmds_pkg::OP_SHIFT;
          cmd.take_round = (cnt == lmds_pkg::LAST_IDX);
        end
      end
      S_TAU:  cmd.op = lmds_pkg::OP_TAU;
      S_MIX:  cmd.op = lmds_pkg::OP_MIX;
      S_RPM:  cmd.op = lmds_pkg::OP_RPM;
      S_ITAU: cmd.op = lmds_pkg::OP_ITAU;
      S_EMIT: begin
        if (out_take) cmd.op = lmds_pkg::OP_SHIFT;
      end
      default: cmd.op = lmds_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (cnt == lmds_pkg::LAST_IDX) begin
              cnt      <= '0;
              in_ready <= 1'b0;
              state    <= S_TAU;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_TAU:  state <= S_MIX;
        S_MIX:  state <= S_RPM;
        S_RPM:  state <= S_ITAU;
        S_ITAU: begin
          out_valid <= 1'b1;
          out_last  <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_take) begin
            if (cnt == lmds_pkg::LAST_IDX) begin
              cnt       <= '0;
              out_valid <= 1'b0;
              out_last  <= 1'b0;
              in_ready  <= 1'b1;
              state     <= S_LOAD;
            end else begin
              cnt      <= cnt + 1'b1;
              out_last <= (cnt == lmds_pkg::LAST_IDX - 1'b1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// File: design/lmds_dp.sv
// State register and the tau, column mix, rotate/pi/mu and inverse tau steps.
module lmds_dp (
  input  logic                  clk,
  input  lmds_pkg::cmd_t        cmd,
  input  lmds_pkg::lane_t       in_lane,
  input  logic [7:0]            in_round,
  output lmds_pkg::lane_t       out_lane
);

  lmds_pkg::lanes_t st;
  lmds_pkg::lanes_t tau_c  [5];
  lmds_pkg::lanes_t itau_c [5];
  lmds_pkg::lanes_t tau_f;
  lmds_pkg::lanes_t itau_f;
  lmds_pkg::lanes_t mix;
  lmds_pkg::lanes_t pib;
  lmds_pkg::lanes_t rpm;
  logic [2:0]       r6;
  logic [2:0]       d;

  assign d        = r6 - 3'd1;
  assign out_lane = st[0];

  for (genvar dd = 0; dd < 5; dd++) begin : g_dir
    for (genvar i = 0; i < lmds_pkg::NLANES; i++) begin : g_lane
      localparam int TS = lmds_pkg::tau_src(dd, i);
      localparam int IS = lmds_pkg::itau_src(dd, i);
      assign tau_c[dd][i]  = st[TS];
      assign itau_c[dd][i] = st[IS];
    end
  end

  // round mod 6 of zero means no tau at all
  always_comb begin
    tau_f  = st;
    itau_f = st;
    if (r6 != 3'd0) begin
      tau_f  = tau_c[d];
      itau_f = itau_c[d];
    end
  end

  // bitsliced Cauchy mix: symbol bit k of column lane i sits in lane i + 5k
  always_comb begin
    lmds_pkg::lane_t acc;
    logic [4:0]      msk;
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < 5; k++) begin
        acc = '0;
        for (int j = 0; j < 5; j++) begin
          msk = lmds_pkg::mul_mask(lmds_pkg::MDS_COEF[i][j], k);
          for (int m = 0; m < 5; m++) begin
            if (msk[m]) acc ^= st[j + 5 * m];
          end
        end
        mix[i + 5 * k] = acc;
      end
    end
  end

  // lane rotations, pi, then mu
  always_comb begin
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        pib[((x + y) % 5) + 5 * ((3 * x) % 5)] =
          lmds_pkg::rotr(st[x + 5 * y], int'(lmds_pkg::ROT_AMT[x + 5 * y]));
      end
    end
    for (int i = 0; i < lmds_pkg::NLANES; i++) begin
      rpm[i] = pib[i] ^ lmds_pkg::rotr(pib[i], 17) ^ lmds_pkg::rotr(pib[i], 32);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_round) r6 <= lmds_pkg::mod6(in_round);
    unique case (cmd.op)
      lmds_pkg::OP_HOLD:  st <= st;
      lmds_pkg::OP_SHIFT: begin
        for (int i = 0; i < lmds_pkg::NLANES - 1; i++) st[i] <= st[i + 1];
        st[lmds_pkg::NLANES - 1] <= in_lane;
      end
      lmds_pkg::OP_TAU:   st <= tau_f;
      lmds_pkg::OP_MIX:   st <= mix;
      lmds_pkg::OP_RPM:   st <= rpm;
      lmds_pkg::OP_ITAU:  st <= itau_f;
      default:            st <= st;
    endcase
  end

endmodule
